// ===== hdl/ikl_pkg.sv =====
// Package for the two-link leg inverse kinematics block.
// Holds the fixed-point formats, CORDIC constants and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ikl_pkg;

    // Fraction bits of positions, lengths and angles
    localparam int F = 16;
    // Angle datapath width (signed, covers +-2pi plus fold headroom)
    localparam int ANG_W = 22;
    // CORDIC x/y datapath width (signed)
    localparam int CORDIC_W = 26;
    // Default and maximum CORDIC depth
    localparam int CORDIC_ITERS_DEF = 18;
    localparam int ATAN_LEN = 28;

    // Register indexes on the configuration port
    localparam logic REG_THIGH_LEN = 1'b0;
    localparam logic REG_SHIN_LEN  = 1'b1;

    // Reset lengths, unsigned Q2.16 meters
    localparam logic [17:0] THIGH_LEN_RST = 18'd6554;
    localparam logic [17:0] SHIN_LEN_RST  = 18'd6554;

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_GAIN    = 64'd652032874;

    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007
    };

    // Q30 constant to Q.F, rounded
    function automatic logic signed [ANG_W-1:0] from_q30(input logic [63:0] v);
        logic [63:0] t;
        t = (v + (64'd1 << (29 - F))) >> (30 - F);
        return t[ANG_W-1:0];
    endfunction

    // Micro-rotation angle of CORDIC step i
    function automatic logic signed [ANG_W-1:0] atan_q(input int i);
        return from_q30({32'd0, ATAN_Q30[i]});
    endfunction

    localparam logic signed [ANG_W-1:0] HALF_PI_Q = from_q30(Q30_HALF_PI);
    localparam logic signed [ANG_W-1:0] PI_Q      = from_q30(Q30_HALF_PI << 1);
    localparam logic signed [ANG_W-1:0] TWO_PI_Q  = PI_Q <<< 1;
    localparam logic signed [ANG_W-1:0] GAIN_Q    = from_q30(Q30_GAIN);

endpackage

// ===== hdl/two_link_leg_inverse_kinematics_top.sv =====
// Throughput: one item per cycle unless the output stalls; stages are registers
// or chain cells (21 + 17 square-root cells, 16 divider cells, four CORDIC chains).
// The whole pipeline advances when the output register is empty or taken.
// rst_n (async, active low) clears all valid bits and loads the reset
// segment lengths; no clearing pass.
`timescale 1ns / 1ps

module two_link_leg_inverse_kinematics_top #(
    parameter int CORDIC_ITERS = ikl_pkg::CORDIC_ITERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: pos_x[19:0], pos_z[39:20], height[59:40], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // tuser: mirror
    input  logic        s_tuser,
    // tdata: hip_angle[19:0], knee_angle[38:20], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // tuser: unreachable
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [17:0] cfg_data
);

    import ikl_pkg::*;

    localparam int AW  = ANG_W;
    localparam int CWD = CORDIC_W;
    localparam int N1  = 21;   // root digits of x^2 + z^2
    localparam int N2  = F + 1; // root digits of 1 - c^2
    localparam int ND  = F;
    localparam int NI  = CORDIC_ITERS;
    localparam logic signed [17:0] ONE    = 18'sd1 <<< F;
    localparam logic [33:0]        ONE_SQ = 34'd1 << (2 * F);
    // Hip bound: 2pi plus 64 LSBs of CORDIC rounding on base and theta
    localparam logic signed [AW-1:0] HIP_LIM = TWO_PI_Q + AW'(64);

    typedef struct packed {
        logic signed [42:0] num;
        logic signed [19:0] x;
        logic signed [20:0] z;
        logic               mir;
    } side1_t;

    typedef struct packed {
        logic               neg;
        logic               fixed;
        logic               unr;
        logic signed [17:0] cfix;
        logic signed [19:0] x;
        logic signed [20:0] z;
        logic               mir;
    } side2_t;

    typedef struct packed {
        logic signed [17:0] c;
        logic signed [19:0] x;
        logic signed [20:0] z;
        logic               mir;
        logic               unr;
    } side3_t;

    typedef struct packed {
        logic               zero;
        logic               mir;
        logic               unr;
        logic signed [19:0] x;
        logic signed [20:0] z;
    } sidet_t;

    typedef struct packed {
        logic                 neg;
        logic signed [AW-1:0] hip;
        logic signed [19:0]   x;
        logic signed [20:0]   z;
        logic                 unr;
    } sides_t;

    typedef struct packed {
        logic                 zero;
        logic signed [AW-1:0] hip;
        logic                 unr;
    } sidek_t;

    typedef struct packed {
        logic signed [CWD-1:0] x;
        logic signed [CWD-1:0] y;
        logic signed [AW-1:0]  a;
        logic                  zero;
    } pre_t;

    // Quadrant pre-rotation for atan2; zero flags the undefined origin
    function automatic pre_t vec_pre(input logic signed [CWD-1:0] x,
                                     input logic signed [CWD-1:0] y);
        pre_t p;
        p.zero = (x == '0) && (y == '0);
        if (x[CWD-1])
        begin
            if (!y[CWD-1])
            begin
                p.x = y;
                p.y = -x;
                p.a = HALF_PI_Q;
            end
            else
            begin
                p.x = -y;
                p.y = x;
                p.a = -HALF_PI_Q;
            end
        end
        else
        begin
            p.x = x;
            p.y = y;
            p.a = '0;
        end
        return p;
    endfunction

    logic        adv;
    logic [17:0] thigh_len_reg;
    logic [17:0] shin_len_reg;

    // Pipeline advance: output register empty or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thigh_len_reg <= THIGH_LEN_RST;
            shin_len_reg  <= SHIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THIGH_LEN: thigh_len_reg <= cfg_data;
                REG_SHIN_LEN:  shin_len_reg  <= cfg_data;
                default:       thigh_len_reg <= thigh_len_reg;
            endcase
        end
    end

    // ---------------- stages A, B, C: offset, squares, sums ----------------
    logic                 a_valid_reg, b_valid_reg, c_valid_reg;
    logic signed [19:0]   a_x_reg, b_x_reg, c_x_reg;
    logic signed [20:0]   a_z_reg, b_z_reg, c_z_reg;
    logic                 a_mir_reg, b_mir_reg, c_mir_reg;
    logic [38:0]          b_xx_reg;
    logic [40:0]          b_zz_reg;
    logic [35:0]          b_ll1_reg, b_ll2_reg;
    logic [41:0]          c_d2_reg;
    logic signed [42:0]   c_num_reg;
    logic signed [20:0]   z_in;
    logic signed [39:0]   xx_full;
    logic signed [41:0]   zz_full;
    logic [41:0]          d2_c;
    logic signed [42:0]   num_c;

    assign z_in    = $signed({s_tdata[39], s_tdata[39:20]})
                   + $signed({s_tdata[59], s_tdata[59:40]});
    assign xx_full = a_x_reg * a_x_reg;
    assign zz_full = a_z_reg * a_z_reg;
    assign d2_c    = {1'b0, b_zz_reg} + {3'b0, b_xx_reg};
    assign num_c   = $signed({1'b0, d2_c}) + $signed({7'b0, b_ll1_reg})
                   - $signed({7'b0, b_ll2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg   <= s_tdata[19:0];
            a_z_reg   <= z_in;
            a_mir_reg <= s_tuser;
            b_x_reg   <= a_x_reg;
            b_z_reg   <= a_z_reg;
            b_mir_reg <= a_mir_reg;
            b_xx_reg  <= xx_full[38:0];
            b_zz_reg  <= zz_full[40:0];
            b_ll1_reg <= thigh_len_reg * thigh_len_reg;
            b_ll2_reg <= shin_len_reg * shin_len_reg;
            c_x_reg   <= b_x_reg;
            c_z_reg   <= b_z_reg;
            c_mir_reg <= b_mir_reg;
            c_d2_reg  <= d2_c;
            c_num_reg <= num_c;
        end
    end

    // ---------------- reach D: square-root chain ----------------
    logic                       s1_valid [0:N1];
    logic [41:0]                s1_v     [0:N1];
    logic [41:0]                s1_r     [0:N1];
    logic [$bits(side1_t)-1:0]  s1_side  [0:N1];
    side1_t                     s1_out;

    assign s1_valid[0] = c_valid_reg;
    assign s1_v[0]     = c_d2_reg;
    assign s1_r[0]     = '0;
    assign s1_side[0]  = {c_num_reg, c_x_reg, c_z_reg, c_mir_reg};

    for (genvar k = 0; k < N1; k++)
    begin : g_sq1
        ikl_sqrt_cell #(
            .W      (42),
            .BITPOS (40 - 2 * k),
            .SW     ($bits(side1_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (s1_valid[k]),
            .in_v      (s1_v[k]),
            .in_r      (s1_r[k]),
            .in_side   (s1_side[k]),
            .out_valid (s1_valid[k+1]),
            .out_v     (s1_v[k+1]),
            .out_r     (s1_r[k+1]),
            .out_side  (s1_side[k+1])
        );
    end

    assign s1_out = side1_t'(s1_side[N1]);

    // ---------------- stage E: denominator 2*L1*D ----------------
    logic               e_valid_reg;
    logic [39:0]        e_den_reg;
    logic signed [42:0] e_num_reg;
    logic signed [19:0] e_x_reg;
    logic signed [20:0] e_z_reg;
    logic               e_mir_reg;
    logic [38:0]        l1d;

    assign l1d = thigh_len_reg * s1_r[N1][20:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (adv)
            e_valid_reg <= s1_valid[N1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_den_reg <= {l1d, 1'b0};
            e_num_reg <= s1_out.num;
            e_x_reg   <= s1_out.x;
            e_z_reg   <= s1_out.z;
            e_mir_reg <= s1_out.mir;
        end
    end

    // ---------------- clamp decision and divider chain ----------------
    logic [42:0]  mag;
    logic         den_zero;
    logic         mag_ge;
    side2_t       d_in_side;

    assign mag      = e_num_reg[42] ? 43'(-e_num_reg) : 43'(e_num_reg);
    assign den_zero = (e_den_reg == '0);
    assign mag_ge   = (mag >= {3'b0, e_den_reg});

    always_comb
    begin
        d_in_side.neg   = e_num_reg[42];
        d_in_side.fixed = den_zero || mag_ge;
        d_in_side.unr   = den_zero || (mag > {3'b0, e_den_reg});
        d_in_side.cfix  = (den_zero || !e_num_reg[42]) ? ONE : -ONE;
        d_in_side.x     = e_x_reg;
        d_in_side.z     = e_z_reg;
        d_in_side.mir   = e_mir_reg;
    end

    logic                       dv_valid [0:ND];
    logic [39:0]                dv_r     [0:ND];
    logic [39:0]                dv_den   [0:ND];
    logic [F-1:0]               dv_q     [0:ND];
    logic [$bits(side2_t)-1:0]  dv_side  [0:ND];
    side2_t                     dv_out;

    assign dv_valid[0] = e_valid_reg;
    assign dv_r[0]     = mag[39:0];
    assign dv_den[0]   = e_den_reg;
    assign dv_q[0]     = '0;
    assign dv_side[0]  = d_in_side;

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        ikl_div_cell #(
            .DW (40),
            .QW (F),
            .SW ($bits(side2_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_valid[k]),
            .in_r      (dv_r[k]),
            .in_den    (dv_den[k]),
            .in_q      (dv_q[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_valid[k+1]),
            .out_r     (dv_r[k+1]),
            .out_den   (dv_den[k+1]),
            .out_q     (dv_q[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    assign dv_out = side2_t'(dv_side[ND]);

    // ---------------- stages G, H: cosine argument, 1 - c^2 ----------------
    logic               g_valid_reg, h_valid_reg;
    logic signed [17:0] g_c_reg, h_c_reg;
    logic signed [19:0] g_x_reg, h_x_reg;
    logic signed [20:0] g_z_reg, h_z_reg;
    logic               g_mir_reg, h_mir_reg;
    logic               g_unr_reg, h_unr_reg;
    logic [33:0]        h_s2_reg;
    logic signed [17:0] q_s;
    logic signed [17:0] c_g;
    logic signed [35:0] cc;

    assign q_s = $signed({2'b0, dv_q[ND]});
    assign c_g = dv_out.fixed ? dv_out.cfix : (dv_out.neg ? -q_s : q_s);
    assign cc  = g_c_reg * g_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= dv_valid[ND];
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_c_reg   <= c_g;
            g_x_reg   <= dv_out.x;
            g_z_reg   <= dv_out.z;
            g_mir_reg <= dv_out.mir;
            g_unr_reg <= dv_out.unr;
            h_s2_reg  <= ONE_SQ - cc[33:0];
            h_c_reg   <= g_c_reg;
            h_x_reg   <= g_x_reg;
            h_z_reg   <= g_z_reg;
            h_mir_reg <= g_mir_reg;
            h_unr_reg <= g_unr_reg;
        end
    end

    // ---------------- sine of theta: square-root chain ----------------
    logic                       s2_valid [0:N2];
    logic [33:0]                s2_v     [0:N2];
    logic [33:0]                s2_r     [0:N2];
    logic [$bits(side3_t)-1:0]  s2_side  [0:N2];
    side3_t                     s2_out;

    assign s2_valid[0] = h_valid_reg;
    assign s2_v[0]     = h_s2_reg;
    assign s2_r[0]     = '0;
    assign s2_side[0]  = {h_c_reg, h_x_reg, h_z_reg, h_mir_reg, h_unr_reg};

    for (genvar k = 0; k < N2; k++)
    begin : g_sq2
        ikl_sqrt_cell #(
            .W      (34),
            .BITPOS (2 * F - 2 * k),
            .SW     ($bits(side3_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (s2_valid[k]),
            .in_v      (s2_v[k]),
            .in_r      (s2_r[k]),
            .in_side   (s2_side[k]),
            .out_valid (s2_valid[k+1]),
            .out_v     (s2_v[k+1]),
            .out_r     (s2_r[k+1]),
            .out_side  (s2_side[k+1])
        );
    end

    assign s2_out = side3_t'(s2_side[N2]);

    // ---------------- theta and base angle: two vectoring chains ----------------
    pre_t   pt, pb;
    sidet_t t_in_side;

    // theta = atan2(sqrt(1 - c^2), c); base = atan2(z, x)
    assign pt = vec_pre(CWD'(s2_out.c), CWD'({1'b0, s2_r[N2][F:0]}));
    assign pb = vec_pre(CWD'(s2_out.x), CWD'(s2_out.z));

    always_comb
    begin
        t_in_side.zero = pt.zero;
        t_in_side.mir  = s2_out.mir;
        t_in_side.unr  = s2_out.unr;
        t_in_side.x    = s2_out.x;
        t_in_side.z    = s2_out.z;
    end

    logic                       ct_valid [0:NI];
    logic signed [CWD-1:0]      ct_x     [0:NI];
    logic signed [CWD-1:0]      ct_y     [0:NI];
    logic signed [AW-1:0]       ct_a     [0:NI];
    logic [$bits(sidet_t)-1:0]  ct_side  [0:NI];
    logic                       cb_valid [0:NI];
    logic signed [CWD-1:0]      cb_x     [0:NI];
    logic signed [CWD-1:0]      cb_y     [0:NI];
    logic signed [AW-1:0]       cb_a     [0:NI];
    logic                       cb_side  [0:NI];
    sidet_t                     ct_out;

    assign ct_valid[0] = s2_valid[N2];
    assign ct_x[0]     = pt.x;
    assign ct_y[0]     = pt.y;
    assign ct_a[0]     = pt.a;
    assign ct_side[0]  = t_in_side;
    assign cb_valid[0] = s2_valid[N2];
    assign cb_x[0]     = pb.x;
    assign cb_y[0]     = pb.y;
    assign cb_a[0]     = pb.a;
    assign cb_side[0]  = pb.zero;

    for (genvar k = 0; k < NI; k++)
    begin : g_atn
        ikl_cordic_cell #(
            .W    (CWD),
            .AW   (AW),
            .STEP (k),
            .ROT  (1'b0),
            .SW   ($bits(sidet_t))
        ) u_theta (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (ct_valid[k]),
            .in_x      (ct_x[k]),
            .in_y      (ct_y[k]),
            .in_a      (ct_a[k]),
            .in_side   (ct_side[k]),
            .out_valid (ct_valid[k+1]),
            .out_x     (ct_x[k+1]),
            .out_y     (ct_y[k+1]),
            .out_a     (ct_a[k+1]),
            .out_side  (ct_side[k+1])
        );

        ikl_cordic_cell #(
            .W    (CWD),
            .AW   (AW),
            .STEP (k),
            .ROT  (1'b0),
            .SW   (1)
        ) u_base (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cb_valid[k]),
            .in_x      (cb_x[k]),
            .in_y      (cb_y[k]),
            .in_a      (cb_a[k]),
            .in_side   (cb_side[k]),
            .out_valid (cb_valid[k+1]),
            .out_x     (cb_x[k+1]),
            .out_y     (cb_y[k+1]),
            .out_a     (cb_a[k+1]),
            .out_side  (cb_side[k+1])
        );
    end

    assign ct_out = sidet_t'(ct_side[NI]);

    // ---------------- stage J: hip angle ----------------
    logic                 j_valid_reg;
    logic signed [AW-1:0] j_hip_reg;
    logic signed [19:0]   j_x_reg;
    logic signed [20:0]   j_z_reg;
    logic                 j_unr_reg;
    logic signed [AW-1:0] theta, base;

    assign theta = ct_out.zero ? '0 : ct_a[NI];
    assign base  = cb_side[NI] ? '0 : cb_a[NI];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_valid_reg <= 1'b0;
        else if (adv)
            j_valid_reg <= ct_valid[NI] && cb_valid[NI];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_hip_reg <= ct_out.mir ? base + theta : base - theta;
            j_x_reg   <= ct_out.x;
            j_z_reg   <= ct_out.z;
            j_unr_reg <= ct_out.unr;
        end
    end

    // ---------------- sin/cos of hip: rotation chain ----------------
    logic signed [AW-1:0] fold_a;
    logic                 fold_neg;
    sides_t               s_in_side;

    // Wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb
    begin
        fold_a   = j_hip_reg;
        fold_neg = 1'b0;
        if (fold_a > PI_Q)
            fold_a = fold_a - TWO_PI_Q;
        if (fold_a < -PI_Q)
            fold_a = fold_a + TWO_PI_Q;
        if (fold_a > HALF_PI_Q)
        begin
            fold_a   = fold_a - PI_Q;
            fold_neg = 1'b1;
        end
        else if (fold_a < -HALF_PI_Q)
        begin
            fold_a   = fold_a + PI_Q;
            fold_neg = 1'b1;
        end
        s_in_side.neg = fold_neg;
        s_in_side.hip = j_hip_reg;
        s_in_side.x   = j_x_reg;
        s_in_side.z   = j_z_reg;
        s_in_side.unr = j_unr_reg;
    end

    logic                       cs_valid [0:NI];
    logic signed [CWD-1:0]      cs_x     [0:NI];
    logic signed [CWD-1:0]      cs_y     [0:NI];
    logic signed [AW-1:0]       cs_a     [0:NI];
    logic [$bits(sides_t)-1:0]  cs_side  [0:NI];
    sides_t                     cs_out;

    assign cs_valid[0] = j_valid_reg;
    assign cs_x[0]     = CWD'(GAIN_Q);
    assign cs_y[0]     = '0;
    assign cs_a[0]     = fold_a;
    assign cs_side[0]  = s_in_side;

    for (genvar k = 0; k < NI; k++)
    begin : g_rot
        ikl_cordic_cell #(
            .W    (CWD),
            .AW   (AW),
            .STEP (k),
            .ROT  (1'b1),
            .SW   ($bits(sides_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cs_valid[k]),
            .in_x      (cs_x[k]),
            .in_y      (cs_y[k]),
            .in_a      (cs_a[k]),
            .in_side   (cs_side[k]),
            .out_valid (cs_valid[k+1]),
            .out_x     (cs_x[k+1]),
            .out_y     (cs_y[k+1]),
            .out_a     (cs_a[k+1]),
            .out_side  (cs_side[k+1])
        );
    end

    assign cs_out = sides_t'(cs_side[NI]);

    // ---------------- stages K, L: thigh tip and foot offset ----------------
    logic                  k_valid_reg, l_valid_reg;
    logic signed [44:0]    k_pc_reg, k_ps_reg;
    logic signed [AW-1:0]  k_hip_reg, l_hip_reg;
    logic signed [19:0]    k_x_reg;
    logic signed [20:0]    k_z_reg;
    logic                  k_unr_reg, l_unr_reg;
    logic signed [CWD-1:0] l_kx_reg, l_kz_reg;
    logic signed [CWD-1:0] co_k, si_k;
    logic signed [18:0]    l1_s;
    logic signed [44:0]    rc_full, rs_full;
    logic signed [CWD-1:0] rc, rs;

    assign co_k    = cs_out.neg ? -cs_x[NI] : cs_x[NI];
    assign si_k    = cs_out.neg ? -cs_y[NI] : cs_y[NI];
    assign l1_s    = $signed({1'b0, thigh_len_reg});
    // Round to nearest, halves up
    assign rc_full = (k_pc_reg + (45'sd1 <<< (F - 1))) >>> F;
    assign rs_full = (k_ps_reg + (45'sd1 <<< (F - 1))) >>> F;
    assign rc      = rc_full[CWD-1:0];
    assign rs      = rs_full[CWD-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            k_valid_reg <= cs_valid[NI];
            l_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_pc_reg  <= l1_s * co_k;
            k_ps_reg  <= l1_s * si_k;
            k_hip_reg <= cs_out.hip;
            k_x_reg   <= cs_out.x;
            k_z_reg   <= cs_out.z;
            k_unr_reg <= cs_out.unr;
            l_kx_reg  <= CWD'(k_x_reg) - rc;
            l_kz_reg  <= CWD'(k_z_reg) - rs;
            l_hip_reg <= k_hip_reg;
            l_unr_reg <= k_unr_reg;
        end
    end

    // ---------------- knee angle: vectoring chain ----------------
    pre_t   pk;
    sidek_t k_in_side;

    assign pk = vec_pre(l_kx_reg, l_kz_reg);

    always_comb
    begin
        k_in_side.zero = pk.zero;
        k_in_side.hip  = l_hip_reg;
        k_in_side.unr  = l_unr_reg;
    end

    logic                       ck_valid [0:NI];
    logic signed [CWD-1:0]      ck_x     [0:NI];
    logic signed [CWD-1:0]      ck_y     [0:NI];
    logic signed [AW-1:0]       ck_a     [0:NI];
    logic [$bits(sidek_t)-1:0]  ck_side  [0:NI];
    sidek_t                     ck_out;

    assign ck_valid[0] = l_valid_reg;
    assign ck_x[0]     = pk.x;
    assign ck_y[0]     = pk.y;
    assign ck_a[0]     = pk.a;
    assign ck_side[0]  = k_in_side;

    for (genvar k = 0; k < NI; k++)
    begin : g_knee
        ikl_cordic_cell #(
            .W    (CWD),
            .AW   (AW),
            .STEP (k),
            .ROT  (1'b0),
            .SW   ($bits(sidek_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (ck_valid[k]),
            .in_x      (ck_x[k]),
            .in_y      (ck_y[k]),
            .in_a      (ck_a[k]),
            .in_side   (ck_side[k]),
            .out_valid (ck_valid[k+1]),
            .out_x     (ck_x[k+1]),
            .out_y     (ck_y[k+1]),
            .out_a     (ck_a[k+1]),
            .out_side  (ck_side[k+1])
        );
    end

    assign ck_out = sidek_t'(ck_side[NI]);

    // ---------------- output register ----------------
    logic                 o_valid_reg;
    logic [19:0]          o_hip_reg;
    logic [18:0]          o_knee_reg;
    logic                 o_unr_reg;
    logic signed [AW-1:0] knee;

    assign knee = ck_out.zero ? '0 : ck_a[NI];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= ck_valid[NI];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_hip_reg  <= ck_out.hip[19:0];
            o_knee_reg <= knee[18:0];
            o_unr_reg  <= ck_out.unr;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, o_knee_reg, o_hip_reg};
    assign m_tuser  = o_unr_reg;

`ifndef SYNTHESIS
    // Cosine argument never leaves [-1, 1]
    a_c_range: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> (g_c_reg <= ONE) && (g_c_reg >= -ONE))
        else $error("cosine argument out of range");

    // Square-root operand follows from the previous argument
    a_s2_value: assert property (@(posedge clk) disable iff (!rst_n)
        (h_valid_reg && $past(adv)) |-> (h_s2_reg <= ONE_SQ))
        else $error("1 - c^2 operand exceeds one");

    // Hip angle stays within about [-2pi, 2pi]
    a_hip_range: assert property (@(posedge clk) disable iff (!rst_n)
        j_valid_reg |-> (j_hip_reg <= HIP_LIM) && (j_hip_reg >= -HIP_LIM))
        else $error("hip angle out of range");

    // Parallel atan2 chains stay in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ct_valid[NI] == cb_valid[NI])
        else $error("theta and base chains out of step");
`endif

endmodule

// ===== hdl/ikl_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root (rounded down).
// Self-contained; the top level chains one cell per result bit.
`timescale 1ns / 1ps

module ikl_sqrt_cell #(
    parameter int W      = 42,
    parameter int BITPOS = 40,
    parameter int SW     = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  in_v,
    input  logic [W-1:0]  in_r,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_v,
    output logic [W-1:0]  out_r,
    output logic [SW-1:0] out_side
);

    localparam logic [W:0] BIT_W1 = {{W{1'b0}}, 1'b1} << BITPOS;

    logic          valid_reg;
    logic [W-1:0]  v_reg, v_next;
    logic [W-1:0]  r_reg, r_next;
    logic [SW-1:0] side_reg;
    logic [W:0]    trial;

    // Trial subtract of r + bit
    assign trial = {1'b0, in_r} + BIT_W1;

    always_comb
    begin
        if ({1'b0, in_v} >= trial)
        begin
            v_next = in_v - trial[W-1:0];
            r_next = (in_r >> 1) + BIT_W1[W-1:0];
        end
        else
        begin
            v_next = in_v;
            r_next = in_r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/ikl_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider.
// Self-contained; the top level chains one cell per fraction bit.
`timescale 1ns / 1ps

module ikl_div_cell #(
    parameter int DW = 40,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] in_r,
    input  logic [DW-1:0] in_den,
    input  logic [QW-1:0] in_q,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_r,
    output logic [DW-1:0] out_den,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;
    logic [DW:0]   r2;
    logic [DW:0]   diff;

    // Shift remainder, try subtracting the divisor
    assign r2   = {in_r, 1'b0};
    assign diff = r2 - {1'b0, in_den};

    always_comb
    begin
        if (r2 >= {1'b0, in_den})
        begin
            r_next = diff[DW-1:0];
            q_next = {in_q[QW-2:0], 1'b1};
        end
        else
        begin
            r_next = r2[DW-1:0];
            q_next = {in_q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_next;
            den_reg  <= in_den;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/ikl_cordic_cell.sv =====
// One micro-rotation cell of a pipelined CORDIC, vectoring or rotation mode.
// Depends on ikl_pkg for the atan table.
`timescale 1ns / 1ps

module ikl_cordic_cell #(
    parameter int W    = 26,
    parameter int AW   = 22,
    parameter int STEP = 0,
    parameter bit ROT  = 1'b0,
    parameter int SW   = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  in_x,
    input  logic signed [W-1:0]  in_y,
    input  logic signed [AW-1:0] in_a,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic signed [W-1:0]  out_x,
    output logic signed [W-1:0]  out_y,
    output logic signed [AW-1:0] out_a,
    output logic [SW-1:0]        out_side
);

    import ikl_pkg::*;

    localparam logic signed [ANG_W-1:0] AT_FULL = atan_q(STEP);
    localparam logic signed [AW-1:0]    AT      = AT_FULL[AW-1:0];

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [AW-1:0] a_reg, a_next;
    logic [SW-1:0]        side_reg;
    logic signed [W-1:0]  dx, dy;
    logic                 cw;

    assign dx = in_y >>> STEP;
    assign dy = in_x >>> STEP;
    // Rotation steers on the residual angle, vectoring on the sign of y
    assign cw = ROT ? in_a[AW-1] : !in_y[W-1];

    always_comb
    begin
        if (cw)
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            a_next = in_a + AT;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            a_next = in_a - AT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            a_reg    <= a_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_a     = a_reg;
    assign out_side  = side_reg;

endmodule

// ===== bench/tb_two_link_leg_inverse_kinematics_top.sv =====
// Self-checking bench for the two-link leg inverse kinematics top level.
// Drives foot targets over the stream port and checks joint angles against a
// bit-exact integer predictor. Depends on ikl_pkg and the top module.
`timescale 1ns / 1ps

module tb_two_link_leg_inverse_kinematics_top;
    import ikl_pkg::*;

    localparam int FB = 16;
    localparam int ITERS = CORDIC_ITERS_DEF;
    localparam int LATENCY = 64 + 3 * ITERS;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [19:0] hip;
        logic [18:0] knee;
        logic        unr;
    } joint_t;

    // Scoreboard: holds expected joint angles in arrival order
    class joint_scoreboard;
        joint_t pending[$];
        int     errors;
        int     checked;

        function void note_target(joint_t j);
            pending.push_back(j);
        endfunction

        function void check_joint(joint_t got);
            joint_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, got.hip);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.hip !== want.hip)
                report_mismatch("hip_angle", want.hip, got.hip);
            if (got.knee !== want.knee)
                report_mismatch("knee_angle", want.knee, got.knee);
            if (got.unr !== want.unr)
                report_mismatch("unreachable", want.unr, got.unr);
        endfunction

        function void report_mismatch(string what, longint want, longint got);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: want %0h got %0h (check %0d)", what, want, got, checked);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [17:0] cfg_data;

    two_link_leg_inverse_kinematics_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    joint_scoreboard sb;
    longint l1_len;
    longint l2_len;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;
    longint cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic longint asr_l(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_to_q(longint v);
        return (v + (64'sd1 << (29 - FB))) >>> (30 - FB);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint off;
        longint ang;
        longint t;
        longint dx;
        longint dy;
        off = 0;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                off = q30_to_q(Q30_HALF_PI);
            end else begin
                x = -y;
                y = t;
                off = -q30_to_q(Q30_HALF_PI);
            end
        end
        for (int i = 0; i < ITERS && i < ATAN_LEN; i++) begin
            dx = asr_l(y, i);
            dy = asr_l(x, i);
            if (y >= 0) begin
                x += dx;
                y -= dy;
                ang += q30_to_q(ATAN_Q30[i]);
            end else begin
                x -= dx;
                y += dy;
                ang -= q30_to_q(ATAN_Q30[i]);
            end
        end
        return off + ang;
    endfunction

    function automatic void rotate_unit(longint a, output longint co, output longint si);
        longint hp;
        longint pi_q;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        hp = q30_to_q(Q30_HALF_PI);
        pi_q = q30_to_q(2 * Q30_HALF_PI);
        x = q30_to_q(Q30_GAIN);
        y = 0;
        flip = 0;
        if (a > pi_q) a -= 2 * pi_q;
        if (a < -pi_q) a += 2 * pi_q;
        if (a > hp) begin
            a -= pi_q;
            flip = 1;
        end else if (a < -hp) begin
            a += pi_q;
            flip = 1;
        end
        for (int i = 0; i < ITERS && i < ATAN_LEN; i++) begin
            dx = asr_l(y, i);
            dy = asr_l(x, i);
            if (a >= 0) begin
                x -= dx;
                y += dy;
                a -= q30_to_q(ATAN_Q30[i]);
            end else begin
                x += dx;
                y -= dy;
                a += q30_to_q(ATAN_Q30[i]);
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    function automatic joint_t solve_leg(logic [19:0] px, logic [19:0] pz,
                                         logic [19:0] ht, logic mir);
        longint x, z, d2, d, num, den, mag, c, q, r, theta, base, hip, knee, co, si;
        longint one;
        joint_t j;
        one = 64'sd1 << FB;
        x = longint'(signed'(px));
        z = longint'(signed'(pz)) + longint'(signed'(ht));
        d2 = x * x + z * z;
        d = int_sqrt(d2);
        num = l1_len * l1_len + d2 - l2_len * l2_len;
        den = 2 * l1_len * d;
        j.unr = 1'b0;
        if (den == 0) begin
            c = one;
            j.unr = 1'b1;
        end else begin
            mag = num < 0 ? -num : num;
            if (mag >= den) begin
                c = num < 0 ? -one : one;
                j.unr = mag > den;
            end else begin
                q = 0;
                r = mag;
                for (int i = 0; i < FB; i++) begin
                    r *= 2;
                    q *= 2;
                    if (r >= den) begin
                        r -= den;
                        q += 1;
                    end
                end
                c = num < 0 ? -q : q;
            end
        end
        theta = vec_angle(int_sqrt(one * one - c * c), c);
        base = vec_angle(z, x);
        hip = mir ? base + theta : base - theta;
        rotate_unit(hip, co, si);
        knee = vec_angle(z - ((l1_len * si + (64'sd1 << (FB - 1))) >>> FB),
                         x - ((l1_len * co + (64'sd1 << (FB - 1))) >>> FB));
        j.hip = hip[19:0];
        j.knee = knee[18:0];
        return j;
    endfunction

    // ---------------- driving ----------------
    task automatic write_reg(logic idx, logic [17:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_THIGH_LEN)
            l1_len = val;
        else
            l2_len = val;
    endtask

    // Offer one target; prediction is taken at the accepting edge
    task automatic send_target(logic [19:0] px, logic [19:0] pz, logic [19:0] ht, logic mir);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'd0, ht, pz, px};
        s_tuser = mir;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_target(solve_leg(px, pz, ht, mir));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Mostly reachable targets for the current lengths, some noise
    task automatic send_random;
        int  kind;
        longint reach;
        logic [19:0] px, pz, ht;
        kind = $urandom_range(9);
        reach = l1_len + l2_len + 1;
        if (kind < 7 && reach < 400000) begin
            px = 20'($signed($urandom_range(2 * reach)) - reach);
            pz = 20'($signed($urandom_range(2 * reach)) - reach);
            ht = 20'($signed($urandom_range(2000)) - 1000);
            pz = pz - ht;
        end else begin
            px = 20'($urandom);
            pz = 20'($urandom);
            ht = 20'($urandom);
        end
        send_target(px, pz, ht, 1'($urandom));
    endtask

    task automatic drain;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Receiver: random stalls plus a one-off long hold-off
    always @(negedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_joint({m_tdata[19:0], m_tdata[38:20], m_tuser});
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[two_link_leg_inverse_kinematics_top] ERROR");
            $finish;
        end
    end

    initial begin
        int phase_items;
        sb = new();
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THIGH_LEN;
        cfg_data = '0;
        l1_len = THIGH_LEN_RST;
        l2_len = SHIN_LEN_RST;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, origin, exact and over reach, both mirrors
        send_target(20'h00000, 20'h00000, 20'h00000, 1'b0);
        send_target(20'h00000, 20'h00000, 20'h00000, 1'b1);
        send_target(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
        send_target(20'h80000, 20'h80000, 20'h80000, 1'b1);
        send_target(20'h80000, 20'h7FFFF, 20'h80000, 1'b0);
        send_target(20'd13108, 20'h00000, 20'h00000, 1'b1);
        send_target(20'd13108, 20'h00000, 20'h00000, 1'b0);
        send_target(20'h00000, -20'd13108, 20'h00000, 1'b0);
        send_target(20'd6554, 20'd3000, -20'd8000, 1'b1);
        send_target(20'd6554, 20'd3000, -20'd8000, 1'b0);
        send_target(-20'd5000, 20'd100, -20'd7000, 1'b1);
        send_target(-20'd5000, 20'd7000, 20'd0, 1'b0);
        send_target(20'd1, 20'd0, 20'd0, 1'b1);
        send_target(20'hFFFFF, 20'd0, 20'd0, 1'b0);
        drain();

        // Zero thigh, then both lengths at 131072 (2.0)
        write_reg(REG_THIGH_LEN, 18'd0);
        send_target(20'd6000, 20'd2000, 20'd0, 1'b1);
        send_target(20'd0, 20'd0, 20'd0, 1'b0);
        drain();
        write_reg(REG_THIGH_LEN, 18'd131072);
        write_reg(REG_SHIN_LEN, 18'd131072);
        send_target(20'd262144, 20'd0, 20'd0, 1'b1);
        send_target(20'd0, -20'd100000, -20'd100000, 1'b0);
        send_target(20'd0, 20'd0, 20'd1, 1'b0);
        drain();

        // Random phases over idling patterns and length settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin
                    send_idle_pct = $urandom_range(30);
                    recv_stall_pct = $urandom_range(30);
                end
            endcase
            case (ph % 4)
                0: begin
                    write_reg(REG_THIGH_LEN, 18'd6554);
                    write_reg(REG_SHIN_LEN, 18'd6554);
                end
                1: begin
                    write_reg(REG_THIGH_LEN, 18'($urandom_range(131072)));
                    write_reg(REG_SHIN_LEN, 18'($urandom_range(131072)));
                end
                2: begin
                    write_reg(REG_THIGH_LEN, 18'($urandom_range(20000, 1)));
                    write_reg(REG_SHIN_LEN, 18'($urandom_range(40000)));
                end
                default: begin
                    write_reg(REG_THIGH_LEN, 18'h3FFFF);
                    write_reg(REG_SHIN_LEN, 18'h3FFFF);
                end
            endcase
            // Long receiver hold-off so the pipeline backs up into the input
            if (ph == 4)
                hold_off_cycles = 400;
            phase_items = 95;
            for (int k = 0; k < phase_items; k++)
                send_random();
            // Sender pauses until all results are back
            drain();
        end

        $display("covered %0d results over 7 random phases with length changes and stalls",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[two_link_leg_inverse_kinematics_top] OK");
        else
            $display("[two_link_leg_inverse_kinematics_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ikl_pkg.sv
hdl/ikl_sqrt_cell.sv
hdl/ikl_div_cell.sv
hdl/ikl_cordic_cell.sv
hdl/two_link_leg_inverse_kinematics_top.sv
bench/tb_two_link_leg_inverse_kinematics_top.sv
